[hw/rtl/bpc_pkg.sv]
// Package for the barometric pressure compensation unit.
// Holds field widths, pipeline depth, shift amounts and register indexes.
// No dependencies.
package bpc_pkg;

    localparam int RawW      = 24;
    localparam int CalW      = 16;
    localparam int DtW       = 25;
    localparam int ProdW     = 42;
    localparam int TempW     = 19;
    localparam int AccW      = 40;
    localparam int SqW       = 36;
    localparam int T2W       = 39;
    localparam int SplitW    = 20;
    localparam int PpLoW     = RawW + SplitW;
    localparam int PpHiW     = RawW + 1 + (AccW - SplitW);
    localparam int FullW     = 66;
    localparam int QW        = 45;
    localparam int DiffW     = 46;
    localparam int PresW     = 32;
    localparam int InDataW   = 48;
    localparam int OutDataW  = 56;
    localparam int NumStages = 10;

    localparam int OffShift  = 7;
    localparam int SensShift = 8;
    localparam int TempShift = 23;
    localparam int ProdShift = 21;
    localparam int PresShift = 15;
    localparam int RefShift  = 8;
    localparam int C2Shift   = 16;
    localparam int C1Shift   = 15;

    localparam logic signed [TempW-1:0] TempBase = TempW'(2000);

    typedef enum logic [2:0] {
        REG_PRESSURE_SENSITIVITY   = 3'd0,
        REG_PRESSURE_OFFSET        = 3'd1,
        REG_SENSITIVITY_TEMP_COEFF = 3'd2,
        REG_OFFSET_TEMP_COEFF      = 3'd3,
        REG_REFERENCE_TEMPERATURE  = 3'd4,
        REG_TEMPERATURE_COEFF      = 3'd5
    } t_cfg_idx;

endpackage

[hw/rtl/barometric_pressure_compensation_unit.sv]
// Throughput: one item per cycle unless the output stalls; each of the ten stages
// holds its item while the next stage is full and stalled, so bubbles close up
// under stall.
// Reset clears the stage valid bits and the six calibration registers.
// Top level of the barometric pressure compensation unit; uses bpc_pkg.
module barometric_pressure_compensation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // raw_temperature [23:0], raw_pressure [47:24]
    input  logic [bpc_pkg::InDataW-1:0]   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // temperature_centi [18:0], pressure_pa [50:19], zero [55:51]
    output logic [bpc_pkg::OutDataW-1:0]  o_m_axis_tdata
);
    import bpc_pkg::*;

    logic [CalW-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] stg_en;
    logic in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_PRESSURE_SENSITIVITY:   r_c1 <= i_cfg_wdata;
                REG_PRESSURE_OFFSET:        r_c2 <= i_cfg_wdata;
                REG_SENSITIVITY_TEMP_COEFF: r_c3 <= i_cfg_wdata;
                REG_OFFSET_TEMP_COEFF:      r_c4 <= i_cfg_wdata;
                REG_REFERENCE_TEMPERATURE:  r_c5 <= i_cfg_wdata;
                REG_TEMPERATURE_COEFF:      r_c6 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        stg_en[NumStages-1] = !r_vld[NumStages-1] || i_m_axis_tready;
        for (int k = NumStages - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign o_s_axis_tready = stg_en[0];
    assign in_fire = i_s_axis_tvalid && stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= in_fire;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 0: temperature difference.
    logic [RawW-1:0] in_d2, in_d1;
    logic signed [DtW-1:0] n0_dt;
    logic signed [DtW-1:0] r0_dt;
    logic [RawW-1:0] r0_d1;

    assign in_d2 = i_s_axis_tdata[RawW-1:0];
    assign in_d1 = i_s_axis_tdata[2*RawW-1:RawW];
    assign n0_dt = $signed({1'b0, in_d2}) - $signed({1'b0, r_c5, {RefShift{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r0_dt <= n0_dt;
            r0_d1 <= in_d1;
        end
    end

    // Stage 1: three coefficient products.
    logic signed [ProdW-1:0] n1_poff, n1_psens, n1_pd;
    logic signed [ProdW-1:0] r1_poff, r1_psens, r1_pd;
    logic [RawW-1:0] r1_d1;

    assign n1_poff  = ProdW'(r0_dt) * ProdW'($signed({1'b0, r_c4}));
    assign n1_psens = ProdW'(r0_dt) * ProdW'($signed({1'b0, r_c3}));
    assign n1_pd    = ProdW'(r0_dt) * ProdW'($signed({1'b0, r_c6}));

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r1_poff  <= n1_poff;
            r1_psens <= n1_psens;
            r1_pd    <= n1_pd;
            r1_d1    <= r0_d1;
        end
    end

    // Stage 2: truncating shifts, first-order offset and sensitivity.
    logic signed [ProdW-1:0] n2_offt, n2_senst, n2_dt;
    logic signed [AccW-1:0] n2_off, n2_sens;
    logic signed [AccW-1:0] r2_off, r2_sens;
    logic signed [TempW-1:0] r2_d;
    logic [RawW-1:0] r2_d1;

    assign n2_offt  = (r1_poff + $signed({{(ProdW-OffShift){1'b0}},
                                          {OffShift{r1_poff[ProdW-1]}}})) >>> OffShift;
    assign n2_senst = (r1_psens + $signed({{(ProdW-SensShift){1'b0}},
                                           {SensShift{r1_psens[ProdW-1]}}})) >>> SensShift;
    assign n2_dt    = (r1_pd + $signed({{(ProdW-TempShift){1'b0}},
                                        {TempShift{r1_pd[ProdW-1]}}})) >>> TempShift;
    assign n2_off   = $signed(AccW'({r_c2, {C2Shift{1'b0}}})) + AccW'(n2_offt);
    assign n2_sens  = $signed(AccW'({r_c1, {C1Shift{1'b0}}})) + AccW'(n2_senst);

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r2_off  <= n2_off;
            r2_sens <= n2_sens;
            r2_d    <= TempW'(n2_dt);
            r2_d1   <= r1_d1;
        end
    end

    // Stage 3: square of the temperature term.
    logic signed [2*TempW-1:0] n3_sq;
    logic [SqW-1:0] r3_dsq;
    logic r3_neg;
    logic signed [TempW-1:0] r3_temp;
    logic signed [AccW-1:0] r3_off, r3_sens;
    logic [RawW-1:0] r3_d1;

    assign n3_sq = (2*TempW)'(r2_d) * (2*TempW)'(r2_d);

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r3_dsq  <= n3_sq[SqW-1:0];
            r3_neg  <= r2_d[TempW-1];
            r3_temp <= r2_d + TempBase;
            r3_off  <= r2_off;
            r3_sens <= r2_sens;
            r3_d1   <= r2_d1;
        end
    end

    // Stage 4: second-order correction below the base temperature.
    logic [T2W-1:0] n4_t2;
    logic signed [AccW-1:0] n4_off_cor, n4_sens_cor;
    logic signed [AccW-1:0] r4_off, r4_sens;
    logic signed [TempW-1:0] r4_temp;
    logic [RawW-1:0] r4_d1;

    assign n4_t2       = T2W'({r3_dsq, 2'b00}) + T2W'(r3_dsq);
    assign n4_off_cor  = r3_neg ? $signed(AccW'(n4_t2 >> 1)) : '0;
    assign n4_sens_cor = r3_neg ? $signed(AccW'(n4_t2 >> 2)) : '0;

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r4_off  <= r3_off - n4_off_cor;
            r4_sens <= r3_sens - n4_sens_cor;
            r4_temp <= r3_temp;
            r4_d1   <= r3_d1;
        end
    end

    // Stage 5: partial products of raw pressure and sensitivity.
    logic [PpLoW-1:0] n5_pplo;
    logic signed [PpHiW-1:0] n5_pphi;
    logic [PpLoW-1:0] r5_pplo;
    logic signed [PpHiW-1:0] r5_pphi;
    logic signed [AccW-1:0] r5_off;
    logic signed [TempW-1:0] r5_temp;

    assign n5_pplo = PpLoW'(r4_d1) * PpLoW'(r4_sens[SplitW-1:0]);
    assign n5_pphi = PpHiW'($signed({1'b0, r4_d1}))
                   * PpHiW'($signed(r4_sens[AccW-1:SplitW]));

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r5_pplo <= n5_pplo;
            r5_pphi <= n5_pphi;
            r5_off  <= r4_off;
            r5_temp <= r4_temp;
        end
    end

    // Stage 6: combine partial products.
    logic signed [FullW-1:0] r6_prod;
    logic signed [AccW-1:0] r6_off;
    logic signed [TempW-1:0] r6_temp;

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r6_prod <= (FullW'(r5_pphi) <<< SplitW) + $signed(FullW'(r5_pplo));
            r6_off  <= r5_off;
            r6_temp <= r5_temp;
        end
    end

    // Stage 7: scale the product, truncating toward zero.
    logic signed [FullW-1:0] n7_q;
    logic signed [QW-1:0] r7_q;
    logic signed [AccW-1:0] r7_off;
    logic signed [TempW-1:0] r7_temp;

    assign n7_q = (r6_prod + $signed({{(FullW-ProdShift){1'b0}},
                                      {ProdShift{r6_prod[FullW-1]}}})) >>> ProdShift;

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r7_q    <= QW'(n7_q);
            r7_off  <= r6_off;
            r7_temp <= r6_temp;
        end
    end

    // Stage 8: subtract the offset.
    logic signed [DiffW-1:0] r8_diff;
    logic signed [TempW-1:0] r8_temp;

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r8_diff <= DiffW'(r7_q) - DiffW'(r7_off);
            r8_temp <= r7_temp;
        end
    end

    // Stage 9: final scaling and saturation to 32 bits.
    logic signed [DiffW-1:0] n9_p;
    logic n9_in_range;
    logic [PresW-1:0] n9_pres;
    logic [PresW-1:0] r9_pres;
    logic signed [TempW-1:0] r9_temp;

    assign n9_p = (r8_diff + $signed({{(DiffW-PresShift){1'b0}},
                                      {PresShift{r8_diff[DiffW-1]}}})) >>> PresShift;
    assign n9_in_range = (&n9_p[DiffW-1:PresW-1]) || !(|n9_p[DiffW-1:PresW-1]);

    always_comb begin
        if (n9_in_range) begin
            n9_pres = n9_p[PresW-1:0];
        end else if (n9_p[DiffW-1]) begin
            n9_pres = {1'b1, {(PresW-1){1'b0}}};
        end else begin
            n9_pres = {1'b0, {(PresW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[9]) begin
            r9_pres <= n9_pres;
            r9_temp <= r8_temp;
        end
    end

    assign o_m_axis_tvalid = r_vld[NumStages-1];
    assign o_m_axis_tdata  = {{(OutDataW-PresW-TempW){1'b0}}, r9_pres, r9_temp};

endmodule

[tb/testbench.sv]
// Self-checking testbench for barometric_pressure_compensation_unit.
// Calibration words go in through the register port and readings stream through the data ports.
// Each result is checked against a wide-integer compensation model; depends on bpc_pkg.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int         CycleLimit  = 200000;
    localparam int         MaxReports  = 10;
    localparam int         IdlePercent = 12;
    localparam int         RawTop      = 16777215;
    localparam logic [2:0] RegSpare6   = 3'd6;
    localparam logic [2:0] RegSpare7   = 3'd7;
    localparam longint     PresMax     = (longint'(1) <<< 31) - 1;
    localparam longint     PresMin     = -(longint'(1) <<< 31);

    typedef struct packed {
        logic signed [TempW-1:0] temperature;
        logic signed [PresW-1:0] pressure;
    } t_reading;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_index = '0;
    logic [CalW-1:0]      cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutDataW-1:0]  m_tdata;

    logic [CalW-1:0] cal_sens = '0;
    logic [CalW-1:0] cal_off = '0;
    logic [CalW-1:0] cal_tcs = '0;
    logic [CalW-1:0] cal_tco = '0;
    logic [CalW-1:0] cal_tref = '0;
    logic [CalW-1:0] cal_tempsens = '0;

    t_reading pending_readings[$];
    bit       steady = 1'b0;
    int       failures = 0;
    int       readings_sent = 0;
    int       results_checked = 0;
    int       cal_sets = 0;
    int       cycle_count = 0;

    barometric_pressure_compensation_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_readings.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(99) >= IdlePercent);
    end

    function automatic longint div_toward_zero(longint v, int k);
        return v / (longint'(1) <<< k);
    endfunction

    function automatic t_reading compensate_reading(logic [RawW-1:0] raw_t,
                                                    logic [RawW-1:0] raw_p);
        longint d2, d1, c1, c2, c3, c4, c5, c6;
        longint dt, off, sens, d, t2, p;
        t_reading r;
        d2 = raw_t;
        d1 = raw_p;
        c1 = cal_sens;
        c2 = cal_off;
        c3 = cal_tcs;
        c4 = cal_tco;
        c5 = cal_tref;
        c6 = cal_tempsens;
        dt = d2 - (c5 <<< RefShift);
        off = (c2 <<< C2Shift) + div_toward_zero(dt * c4, OffShift);
        sens = (c1 <<< C1Shift) + div_toward_zero(dt * c3, SensShift);
        d = div_toward_zero(dt * c6, TempShift);
        if (d < 0) begin
            t2 = 5 * d * d;
            off = off - (t2 >>> 1);
            sens = sens - (t2 >>> 2);
        end
        p = div_toward_zero(div_toward_zero(d1 * sens, ProdShift) - off, PresShift);
        if (p > PresMax) p = PresMax;
        if (p < PresMin) p = PresMin;
        r.temperature = TempW'(d + longint'(TempBase));
        r.pressure = PresW'(p);
        return r;
    endfunction

    always @(negedge clk) begin : check_results
        t_reading             want;
        logic [TempW-1:0]     got_temp;
        logic [PresW-1:0]     got_pres;
        logic [OutDataW-TempW-PresW-1:0] got_pad;
        if (rst_n && m_tvalid && m_tready) begin
            results_checked++;
            got_temp = m_tdata[TempW-1:0];
            got_pres = m_tdata[TempW+PresW-1:TempW];
            got_pad = m_tdata[OutDataW-1:TempW+PresW];
            if (pending_readings.size() == 0) begin
                failures++;
                if (failures <= MaxReports)
                    $display("Unexpected result transfer at %0t: data %h", $realtime, m_tdata);
            end else begin
                want = pending_readings.pop_front();
                if (got_temp !== want.temperature || got_pres !== want.pressure ||
                    got_pad !== '0) begin
                    failures++;
                    if (failures <= MaxReports)
                        $display({"Mismatch at %0t: temperature %0d (expected %0d), ",
                                  "pressure %0d (expected %0d), padding %h"},
                                 $realtime, $signed(got_temp), want.temperature,
                                 $signed(got_pres), want.pressure, got_pad);
                end
            end
        end
    end

    task automatic send_reading(input logic [RawW-1:0] raw_t, input logic [RawW-1:0] raw_p);
        logic     taken;
        t_reading want;
        want = compensate_reading(raw_t, raw_p);
        while (!steady && $urandom_range(99) < IdlePercent) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {raw_p, raw_t};
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = s_tready;
            if (taken) pending_readings.push_back(want);
            @(posedge clk);
        end
        readings_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [CalW-1:0] val,
                                  input bit last);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_PRESSURE_SENSITIVITY:   cal_sens = val;
            REG_PRESSURE_OFFSET:        cal_off = val;
            REG_SENSITIVITY_TEMP_COEFF: cal_tcs = val;
            REG_OFFSET_TEMP_COEFF:      cal_tco = val;
            REG_REFERENCE_TEMPERATURE:  cal_tref = val;
            REG_TEMPERATURE_COEFF:      cal_tempsens = val;
            default: ;
        endcase
        if (last) cfg_we <= 1'b0;
    endtask

    task automatic program_calibration(input logic [CalW-1:0] c1, input logic [CalW-1:0] c2,
                                       input logic [CalW-1:0] c3, input logic [CalW-1:0] c4,
                                       input logic [CalW-1:0] c5, input logic [CalW-1:0] c6);
        wait_idle();
        write_register(REG_PRESSURE_SENSITIVITY, c1, 1'b0);
        write_register(REG_PRESSURE_OFFSET, c2, 1'b0);
        write_register(REG_SENSITIVITY_TEMP_COEFF, c3, 1'b0);
        write_register(REG_OFFSET_TEMP_COEFF, c4, 1'b0);
        write_register(REG_REFERENCE_TEMPERATURE, c5, 1'b0);
        write_register(REG_TEMPERATURE_COEFF, c6, 1'b1);
        cal_sets++;
    endtask

    function automatic logic [CalW-1:0] pick_cal_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return CalW'($urandom);
        endcase
    endfunction

    // Readings near the reference temperature exercise small positive and negative offsets.
    function automatic logic [RawW-1:0] pick_raw_temperature();
        int v;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: begin
                v = int'(cal_tref) * 256 + int'($urandom_range(0, 1 << 20)) - (1 << 19);
                if (v < 0) v = 0;
                if (v > RawTop) v = RawTop;
                return RawW'(v);
            end
            default: return RawW'($urandom);
        endcase
    endfunction

    function automatic logic [RawW-1:0] pick_raw_pressure();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return RawW'($urandom);
        endcase
    endfunction

    task automatic test_zero_calibration();
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading('1, '0);
        send_reading('0, '1);
    endtask

    task automatic test_typical_calibration();
        program_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        send_reading(24'd8569150, 24'd9085466);
        send_reading('0, 24'd9085466);
        send_reading('1, 24'd9085466);
    endtask

    task automatic test_full_scale_calibration();
        program_calibration('1, '1, '1, '1, '1, '1);
        send_reading('0, '1);
        send_reading('0, '0);
        send_reading('1, '1);
        send_reading('1, '0);
    endtask

    task automatic test_second_order_threshold();
        program_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, '1, 16'd1);
        send_reading(24'd8388352, 24'd9085466);
        send_reading(24'd8388353, 24'd9085466);
        send_reading(24'd8388351, 24'd9085466);
    endtask

    task automatic test_unused_register_index();
        wait_idle();
        write_register(RegSpare6, '1, 1'b0);
        write_register(RegSpare7, '0, 1'b1);
        send_reading(24'd8388352, '1);
        send_reading(24'd4000000, 24'd123456);
    endtask

    task automatic test_random_calibrations();
        for (int s = 0; s < 20; s++) begin
            program_calibration(pick_cal_word(), pick_cal_word(), pick_cal_word(),
                                pick_cal_word(), pick_cal_word(), pick_cal_word());
            for (int n = 0; n < 50; n++) send_reading(pick_raw_temperature(), pick_raw_pressure());
        end
    endtask

    task automatic test_back_to_back();
        program_calibration(pick_cal_word(), pick_cal_word(), pick_cal_word(),
                            pick_cal_word(), pick_cal_word(), pick_cal_word());
        steady = 1'b1;
        for (int n = 0; n < 150; n++) send_reading(pick_raw_temperature(), pick_raw_pressure());
        steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_calibration();
        test_typical_calibration();
        test_full_scale_calibration();
        test_second_order_threshold();
        test_unused_register_index();
        test_random_calibrations();
        test_back_to_back();
        wait_idle();
        repeat (NumStages + 4) @(posedge clk);
        $display("Sent %0d readings across %0d calibration sets, including all-zero, full-scale,",
                 readings_sent, cal_sets + 1);
        $display("second-order threshold and unused register cases; %0d results checked, %0d bad.",
                 results_checked, failures);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
